// File: hw/rtl/pmqm_pkg.sv
// shared types and constants for the port message queue manager
// no dependencies
package pmqm_pkg;

    localparam int NUM_PORTS_DEF = 16;
    localparam int NUM_SLOTS_DEF = 64;
    localparam int MAX_BYTES_DEF = 8;

    typedef enum logic [2:0] {
        KIND_CREATE  = 3'd0,
        KIND_DESTROY = 3'd1,
        KIND_SEND    = 3'd2,
        KIND_RECV    = 3'd3,
        KIND_RECV_TY = 3'd4,
        KIND_NOTIFY  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_PORT   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_NO_MSG    = 3'd4
    } status_t;

    // one transaction as queued between front and back
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] target_port;
        logic [15:0] source_port;
        logic [31:0] message_type;
        logic [15:0] byte_count;
        logic [63:0] payload_word;
        logic        notify_enable;
    } cmd_t;

    function automatic logic [15:0] bump(input logic [15:0] c);
        logic [15:0] r;
        r = (c == 16'hFFFF) ? 16'd1 : c + 16'd1;
        return r;
    endfunction

endpackage

// File: hw/rtl/port_message_queue_manager.sv
// top level of the port message queue manager
// depends on pmqm_pkg, pmqm_front, pmqm_back
//
// Command-driven mailbox with per-port message queues in a shared slot pool.
// Raise start with the command fields; the transaction is taken at a rising edge
// where busy is low. Each transaction returns exactly one result, marked by done
// for exactly one cycle; the receiver cannot stall it, so it must be taken then.
// The back end takes each command, scans the port table one port entry per cycle
// for the id match and a free entry, then dispatches and replies, raising done.
// A send to a non-empty queue also reads and relinks the old tail record, a receive
// reads the head record, destroy and receive by type walk the queue slot by slot,
// and a receive by type that removes a message behind the head also reads and
// relinks its predecessor record.
// A two-entry command queue in front lets commands be issued while earlier ones run.
module port_message_queue_manager
    import pmqm_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] target_port,
    input  logic [15:0] source_port,
    input  logic [31:0] message_type,
    input  logic [15:0] byte_count,
    input  logic [63:0] payload_word,
    input  logic        notify_enable,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] new_port,
    output logic [15:0] message_id,
    output logic [15:0] from_port,
    output logic [31:0] received_type,
    output logic [15:0] received_size,
    output logic [63:0] received_payload,
    output logic        notify,
    output logic [$clog2(NUM_PORTS+1)-1:0] port_count
);

    cmd_t cmd_in;
    cmd_t cmd_q;
    logic avail;
    logic take;

    assign cmd_in = '{kind, target_port, source_port, message_type,
                      byte_count, payload_word, notify_enable};

    pmqm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd_in  (cmd_in),
        .busy    (busy),
        .take    (take),
        .avail   (avail),
        .cmd_out (cmd_q)
    );

    pmqm_back #(
        .NUM_PORTS (NUM_PORTS),
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .avail            (avail),
        .cmd              (cmd_q),
        .take             (take),
        .done             (done),
        .status           (status),
        .new_port         (new_port),
        .message_id       (message_id),
        .from_port        (from_port),
        .received_type    (received_type),
        .received_size    (received_size),
        .received_payload (received_payload),
        .notify           (notify),
        .port_count       (port_count)
    );

endmodule

// File: hw/rtl/pmqm_front.sv
// front end: takes command transactions into a short queue
// depends on pmqm_pkg
module pmqm_front
    import pmqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd_in,
    output logic busy,
    input  logic take,
    output logic avail,
    output cmd_t cmd_out
);

    // two entry queue
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    logic push;
    logic pop;

    assign push    = start && !busy;
    assign pop     = take && avail;
    assign avail   = cnt_reg != 2'd0;
    assign busy    = cnt_reg == 2'd2;
    assign cmd_out = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wr_reg] <= cmd_in;
                wr_reg        <= ~wr_reg;
            end
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: hw/rtl/pmqm_back.sv
// back end: port table, slot pool and list walks over a slot memory
// depends on pmqm_pkg
module pmqm_back
    import pmqm_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  cmd_t        cmd,
    output logic        take,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] new_port,
    output logic [15:0] message_id,
    output logic [15:0] from_port,
    output logic [31:0] received_type,
    output logic [15:0] received_size,
    output logic [63:0] received_payload,
    output logic        notify,
    output logic [$clog2(NUM_PORTS+1)-1:0] port_count
);

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int NW = $clog2(NUM_PORTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DISPATCH, S_WALK_RD, S_WALK, S_RD_HEAD,
        S_HEAD, S_LINK, S_REPLY
    } state_t;

    // slot record in memory
    typedef struct packed {
        logic [SW-1:0] nxt;
        logic [15:0]   ident;
        logic [15:0]   sender;
        logic [31:0]   mtype;
        logic [15:0]   size;
        logic [63:0]   payload;
    } slot_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    // port table (small, flops)
    logic [NUM_PORTS-1:0] pvalid_reg;
    logic [NUM_PORTS-1:0] pnotify_reg;
    logic [15:0]   pident_reg   [NUM_PORTS];
    logic [SW-1:0] phead_reg    [NUM_PORTS];
    logic [SW-1:0] ptail_reg    [NUM_PORTS];
    logic [CW-1:0] ppending_reg [NUM_PORTS];
    logic [NUM_SLOTS-1:0] svalid_reg;

    // slot memory, one write and one read port
    slot_t         mem [NUM_SLOTS];
    slot_t         rdata_reg;
    logic          mwe;
    logic [SW-1:0] mwa;
    slot_t         mwd;
    logic [SW-1:0] mra;

    logic [15:0]   pcnt_reg;
    logic [15:0]   mcnt_reg;
    logic [PW-1:0] pidx_reg;
    logic          pfound_reg;
    logic [PW-1:0] pfree_reg;
    logic          pfree_ok_reg;
    logic [SW-1:0] sfree_reg;
    logic          sfree_ok_reg;
    logic [CW-1:0] k_reg;
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] prev_reg;
    logic          have_prev_reg;
    logic [NW-1:0] nports_reg;
    logic [PW:0]   scan_reg;

    // record written back on a relink
    slot_t         link_reg;
    slot_t         link_c;

    // registered result
    logic          done_reg;
    logic [2:0]    status_reg;
    logic [15:0]   new_port_reg;
    logic [15:0]   msg_id_reg;
    logic          notify_reg;
    slot_t         rx_reg;
    logic          rx_on_reg;

    assign take             = (state_reg == S_IDLE) && avail;
    assign done             = done_reg;
    assign status           = status_reg;
    assign new_port         = new_port_reg;
    assign message_id       = rx_on_reg ? rx_reg.ident : msg_id_reg;
    assign from_port        = rx_on_reg ? rx_reg.sender : 16'd0;
    assign received_type    = rx_on_reg ? rx_reg.mtype : 32'd0;
    assign received_size    = rx_on_reg ? rx_reg.size : 16'd0;
    assign received_payload = rx_on_reg ? rx_reg.payload : 64'd0;
    assign notify           = notify_reg;
    assign port_count       = nports_reg;

    // lowest free slot, priority encoder
    logic [SW-1:0] sfree_c;
    logic          sfree_ok_c;
    always_comb
    begin
        sfree_c    = '0;
        sfree_ok_c = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!svalid_reg[i])
            begin
                sfree_c    = SW'(i);
                sfree_ok_c = 1'b1;
            end
        end
    end

    // masked payload
    logic [63:0] pay_mask;
    always_comb
    begin
        for (int b = 0; b < 8; b++)
            pay_mask[b*8 +: 8] = (cmd_reg.byte_count > 16'(b)) ? 8'hFF : 8'h00;
    end

    // predecessor record with its new next pointer: the new slot on a send,
    // the removed slot's successor on a receive by type
    always_comb
    begin
        link_c     = rdata_reg;
        link_c.nxt = (cmd_reg.kind == KIND_SEND) ? sfree_reg : rx_reg.nxt;
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[mwa] <= mwd;
        rdata_reg <= mem[mra];
    end

    logic [PW-1:0] scan_idx;
    assign scan_idx = scan_reg[PW-1:0];

    // memory control decode
    always_comb
    begin
        mwe = 1'b0;
        mwa = sfree_reg;
        mwd = '0;
        mra = cur_reg;
        if (state_reg == S_DISPATCH)
            mra = phead_reg[pidx_reg];
        else if (state_reg == S_WALK)
            mra = rdata_reg.nxt;
        else if (state_reg == S_RD_HEAD)
            mra = prev_reg;
        if (state_reg == S_DISPATCH && cmd_reg.kind == KIND_SEND && pfound_reg
            && cmd_reg.byte_count <= 16'(MAX_BYTES) && sfree_ok_reg)
        begin
            mwe         = 1'b1;
            mwa         = sfree_reg;
            mwd.nxt     = '0;
            mwd.ident   = mcnt_reg;
            mwd.sender  = cmd_reg.source_port;
            mwd.mtype   = cmd_reg.message_type;
            mwd.size    = cmd_reg.byte_count;
            mwd.payload = cmd_reg.payload_word & pay_mask;
        end
        else if (state_reg == S_LINK)
        begin
            // relink tail to new slot or unlink matched slot
            mwe     = 1'b1;
            mwa     = prev_reg;
            mwd     = link_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pvalid_reg   <= '0;
            pnotify_reg  <= '0;
            svalid_reg   <= '0;
            pcnt_reg     <= 16'd1;
            mcnt_reg     <= 16'd1;
            nports_reg   <= '0;
            done_reg     <= 1'b0;
            rx_on_reg    <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
                ppending_reg[i] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        cmd_reg      <= cmd;
                        scan_reg     <= '0;
                        pfound_reg   <= 1'b0;
                        pfree_ok_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                // one port entry per cycle: id match and free entry
                S_SCAN:
                begin
                    if (!pvalid_reg[scan_idx] && !pfree_ok_reg)
                    begin
                        pfree_ok_reg <= 1'b1;
                        pfree_reg    <= scan_idx;
                    end
                    if (pvalid_reg[scan_idx] && !pfound_reg
                        && pident_reg[scan_idx] == cmd_reg.target_port)
                    begin
                        pfound_reg <= 1'b1;
                        pidx_reg   <= scan_idx;
                    end
                    sfree_reg    <= sfree_c;
                    sfree_ok_reg <= sfree_ok_c;
                    scan_reg     <= scan_reg + 1'b1;
                    if (scan_reg == (PW+1)'(NUM_PORTS - 1))
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    status_reg    <= ST_OK;
                    new_port_reg  <= '0;
                    msg_id_reg    <= '0;
                    notify_reg    <= 1'b0;
                    rx_on_reg     <= 1'b0;
                    k_reg         <= '0;
                    have_prev_reg <= 1'b0;
                    cur_reg       <= phead_reg[pidx_reg];
                    state_reg     <= S_REPLY;
                    if (cmd_reg.kind == KIND_CREATE)
                    begin
                        if (!pfree_ok_reg)
                            status_reg <= ST_NO_SLOT;
                        else
                        begin
                            pvalid_reg[pfree_reg]   <= 1'b1;
                            pident_reg[pfree_reg]   <= pcnt_reg;
                            ppending_reg[pfree_reg] <= '0;
                            pnotify_reg[pfree_reg]  <= 1'b0;
                            new_port_reg            <= pcnt_reg;
                            pcnt_reg                <= bump(pcnt_reg);
                            nports_reg              <= nports_reg + 1'b1;
                        end
                    end
                    else if (cmd_reg.kind <= KIND_NOTIFY)
                    begin
                        if (!pfound_reg)
                            status_reg <= ST_NO_PORT;
                        else if (cmd_reg.kind == KIND_DESTROY)
                        begin
                            pvalid_reg[pidx_reg]  <= 1'b0;
                            pnotify_reg[pidx_reg] <= 1'b0;
                            nports_reg            <= nports_reg - 1'b1;
                            if (ppending_reg[pidx_reg] != '0)
                                state_reg <= S_WALK_RD;
                        end
                        else if (cmd_reg.kind == KIND_SEND)
                        begin
                            if (cmd_reg.byte_count > 16'(MAX_BYTES))
                                status_reg <= ST_TOO_LARGE;
                            else if (!sfree_ok_reg)
                                status_reg <= ST_NO_SLOT;
                            else
                            begin
                                svalid_reg[sfree_reg]   <= 1'b1;
                                ptail_reg[pidx_reg]     <= sfree_reg;
                                ppending_reg[pidx_reg]  <= ppending_reg[pidx_reg] + 1'b1;
                                msg_id_reg              <= mcnt_reg;
                                notify_reg              <= pnotify_reg[pidx_reg];
                                mcnt_reg                <= bump(mcnt_reg);
                                if (ppending_reg[pidx_reg] == '0)
                                    phead_reg[pidx_reg] <= sfree_reg;
                                else
                                begin
                                    // read old tail record, then relink it
                                    cur_reg   <= ptail_reg[pidx_reg];
                                    prev_reg  <= ptail_reg[pidx_reg];
                                    state_reg <= S_RD_HEAD;
                                end
                            end
                        end
                        else if (cmd_reg.kind == KIND_NOTIFY)
                            pnotify_reg[pidx_reg] <= cmd_reg.notify_enable;
                        else if (ppending_reg[pidx_reg] == '0)
                            status_reg <= ST_NO_MSG;
                        else
                            state_reg <= S_WALK_RD;
                    end
                end
                // wait for the predecessor record read
                S_RD_HEAD:
                    state_reg <= S_HEAD;
                S_HEAD:
                begin
                    link_reg  <= link_c;
                    state_reg <= S_LINK;
                end
                S_LINK:
                    state_reg <= S_REPLY;
                // the read of cur_reg is registered; its data is used in S_WALK
                S_WALK_RD:
                    state_reg <= S_WALK;
                S_WALK:
                begin
                    if (cmd_reg.kind == KIND_DESTROY)
                    begin
                        svalid_reg[cur_reg] <= 1'b0;
                        cur_reg             <= rdata_reg.nxt;
                        k_reg               <= k_reg + 1'b1;
                        if (k_reg + 1'b1 == ppending_reg[pidx_reg])
                        begin
                            ppending_reg[pidx_reg] <= '0;
                            state_reg              <= S_REPLY;
                        end
                    end
                    else if (cmd_reg.kind == KIND_RECV
                             || rdata_reg.mtype == cmd_reg.message_type)
                    begin
                        // take this message out
                        svalid_reg[cur_reg]    <= 1'b0;
                        ppending_reg[pidx_reg] <= ppending_reg[pidx_reg] - 1'b1;
                        rx_reg                 <= rdata_reg;
                        rx_on_reg              <= 1'b1;
                        if (!have_prev_reg)
                        begin
                            phead_reg[pidx_reg] <= rdata_reg.nxt;
                            state_reg           <= S_REPLY;
                        end
                        else
                        begin
                            if (k_reg + 1'b1 == ppending_reg[pidx_reg])
                                ptail_reg[pidx_reg] <= prev_reg;
                            state_reg <= S_RD_HEAD;
                        end
                    end
                    else
                    begin
                        have_prev_reg <= 1'b1;
                        prev_reg      <= cur_reg;
                        cur_reg       <= rdata_reg.nxt;
                        k_reg         <= k_reg + 1'b1;
                        if (k_reg + 1'b1 == ppending_reg[pidx_reg])
                        begin
                            status_reg <= ST_NO_MSG;
                            state_reg  <= S_REPLY;
                        end
                    end
                end
                S_REPLY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
